// ===== rtl/core/srtf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Item types, field widths and codes shared by the scheduler files.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int TIME_W        = 18;
  localparam int ARRIVAL_W     = 16;
  localparam int BURST_W       = 12;
  localparam int RAN_ID_W      = 5;
  localparam int DEF_MAX_PROCS = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [ARRIVAL_W-1:0] arrival_time;
    logic [BURST_W-1:0]   burst_time;
  } cmd_item_t;

  typedef struct packed {
    logic                load_error;
    logic [RAN_ID_W-1:0] ran_id;
    logic [TIME_W-1:0]   time_now;
    logic                finished;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic [TIME_W-1:0]   response;
    logic                all_done;
  } rsp_item_t;

  // One process table entry as held in the table memory.
  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;
    logic [BURST_W-1:0]   remaining;
    logic [TIME_W-1:0]    response;
  } proc_entry_t;

  localparam int ENTRY_W = $bits(proc_entry_t);

endpackage

// ===== rtl/core/srtf_preemptive_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler
// Shortest-remaining-time-first scheduler over a process table in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the cmd channel (cmd_valid / cmd_stall / cmd) and every item
// produces exactly one result item on the rsp channel (rsp_valid / rsp_stall /
// rsp). A load item appends a process to the table; a tick item advances time
// by one unit and runs the arrived process with the least remaining work.
// A load, or a tick when nothing is left to run, which leaves time as it is,
// is answered in the cycle after it is taken. A tick that schedules steps
// through a scan state with one read per loaded slot through the single read
// port of the table RAM, a drain state for the last read to return, a
// write-back state, a turnaround state and a done state that works out the
// waiting time and writes the result; the next item is taken back in idle.
// The block works on one item at a time; cmd_stall is high while a tick is in
// flight. The result sits in an output register, so a stalled receiver only
// holds the block once the next result is ready to be written.
// Reset clears the process count, the unfinished count, elapsed time and the
// handshake state. The table RAM is not cleared: only loaded slots are read.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  // Slot index and count widths follow from the table depth.
  localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int IDW = IW + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_TAT   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  logic [2:0]        state;
  logic [CW-1:0]     proc_count;
  logic [CW-1:0]     unfinished;
  logic [TIME_W-1:0] elapsed;

  // Scan bookkeeping.
  logic [IW-1:0]     scan_idx;
  logic              rd_pend;
  logic [IW-1:0]     pend_idx;
  logic              found;
  logic [IW-1:0]     best_idx;
  proc_entry_t       best;

  // Results of the write-back and turnaround states.
  logic              fin;
  logic [TIME_W-1:0] resp_val;
  logic [TIME_W-1:0] tat;

  // RAM ports.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  proc_entry_t       ram_wdata;
  logic              ram_rd_en;
  proc_entry_t       ram_rdata;

  logic              out_free;
  logic              cmd_acc;
  logic              ld_ok;
  logic              busy_tick;
  logic              first_run;
  logic [BURST_W-1:0] rem_next;
  logic [TIME_W-1:0] resp_next;
  logic [TIME_W-1:0] elapsed_adv;
  logic              take;
  logic [IDW-1:0]    id_full;
  logic              rsp_set;

  // The output register can take a new result when it is empty or being read.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign ld_ok     = (cmd.burst_time != '0) && (proc_count < CW'(MAX_PROCS));
  assign busy_tick = (cmd.kind == KIND_TICK) && (unfinished != '0);

  // A tick that schedules does not need the output register until its end,
  // so it may start while the previous result is still waiting.
  assign cmd_stall = (state != S_IDLE) || (!out_free && !busy_tick);
  assign cmd_acc   = cmd_valid && !cmd_stall;

  // A result is written for a load, for a tick with nothing left to run, and
  // at the end of a scheduling tick.
  assign rsp_set = (cmd_acc && ((cmd.kind == KIND_LOAD) || (unfinished == '0)))
                || ((state == S_DONE) && out_free);

  assign elapsed_adv = (elapsed != TIME_MAX) ? (elapsed + 1'b1) : elapsed;

  // Run of the chosen entry, used in the write-back cycle.
  assign first_run = (best.remaining == best.burst);
  assign rem_next  = best.remaining - 1'b1;
  assign resp_next = first_run ? sat_sub(elapsed, TIME_W'(best.arrival)) : best.response;

  // Candidate test on the entry returning from the RAM.
  assign take = rd_pend
             && (TIME_W'(ram_rdata.arrival) <= elapsed)
             && (ram_rdata.remaining != '0)
             && (!found || (ram_rdata.remaining < best.remaining));

  assign id_full = IDW'(best_idx) + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_count[IW-1:0];
    ram_wdata = '{arrival:   cmd.arrival_time,
                  burst:     cmd.burst_time,
                  remaining: cmd.burst_time,
                  response:  '0};
    if (state == S_WB) begin
      ram_we    = found;
      ram_waddr = best_idx;
      ram_wdata = '{arrival:   best.arrival,
                    burst:     best.burst,
                    remaining: rem_next,
                    response:  resp_next};
    end else if (cmd_acc && (cmd.kind == KIND_LOAD) && ld_ok) begin
      ram_we = 1'b1;
    end
    ram_rd_en = (state == S_SCAN);
  end

  srtf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rd_en (ram_rd_en),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      proc_count <= '0;
      unfinished <= '0;
      elapsed    <= '0;
      rsp_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // Track the best candidate as scanned entries come back from the RAM.
      rd_pend <= (state == S_SCAN);
      if (take) begin
        found    <= 1'b1;
        best_idx <= pend_idx;
        best     <= ram_rdata;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.kind == KIND_LOAD) begin
              // Loads are answered at once; the entry is written this cycle.
              rsp <= '{load_error:      !ld_ok,
                       ran_id:          '0,
                       time_now:        elapsed,
                       finished:        1'b0,
                       completion_time: '0,
                       turnaround:      '0,
                       waiting:         '0,
                       response:        '0,
                       all_done:        !ld_ok && (unfinished == '0)};
              if (ld_ok) begin
                proc_count <= proc_count + 1'b1;
                unfinished <= unfinished + 1'b1;
              end
            end else if (unfinished == '0) begin
              // Nothing left to run: report and leave the state alone.
              rsp <= '{load_error:      1'b0,
                       ran_id:          '0,
                       time_now:        elapsed,
                       finished:        1'b0,
                       completion_time: '0,
                       turnaround:      '0,
                       waiting:         '0,
                       response:        '0,
                       all_done:        1'b1};
            end else begin
              state    <= S_SCAN;
              scan_idx <= '0;
              found    <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          pend_idx <= scan_idx;
          if (CW'(scan_idx) == proc_count - 1'b1) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_WB;
        end
        S_WB: begin
          elapsed  <= elapsed_adv;
          fin      <= found && (rem_next == '0);
          resp_val <= resp_next;
          if (found && (rem_next == '0)) begin
            unfinished <= unfinished - 1'b1;
          end
          state <= S_TAT;
        end
        S_TAT: begin
          tat   <= sat_sub(elapsed, TIME_W'(best.arrival));
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp <= '{load_error:      1'b0,
                     ran_id:          found ? RAN_ID_W'(id_full) : '0,
                     time_now:        elapsed,
                     finished:        fin,
                     completion_time: fin ? elapsed : '0,
                     turnaround:      fin ? tat : '0,
                     waiting:         fin ? sat_sub(tat, TIME_W'(best.burst)) : '0,
                     response:        fin ? resp_val : '0,
                     all_done:        (unfinished == '0)};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The unfinished count can never exceed the number of loaded processes.
  a_unfinished_le_count: assert property (@(posedge clk) disable iff (rst)
    unfinished <= proc_count)
    else $error("unfinished count exceeds process count");

  // The table is never written while a scan is reading it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN) |-> !ram_we)
    else $error("table written during scan");

  // Elapsed time never moves backward.
  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> elapsed >= $past(elapsed))
    else $error("elapsed time decreased");

  // A result marked finished always names the process that ran.
  a_finish_has_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && fin) |-> found)
    else $error("completion without a scheduled process");

endmodule

// ===== rtl/core/srtf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/srtf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler checker
// Watches both channels of the scheduler, predicts every result item from
// the accepted input items and compares the two field by field.
// ----------------------------------------------------------------------------
module srtf_checker
  import srtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  cmd_item_t cmd,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  rsp_item_t rsp,
  output int        fail_count,
  output int        pending
);

  localparam int REPORT_CAP = 40;

  // Private copy of the process table and the scheduler counters.
  logic [ARRIVAL_W-1:0] arrival_of   [DEF_MAX_PROCS];
  logic [BURST_W-1:0]   burst_of     [DEF_MAX_PROCS];
  logic [BURST_W-1:0]   left_of      [DEF_MAX_PROCS];
  logic [TIME_W-1:0]    first_run_of [DEF_MAX_PROCS];
  int                   loaded;
  int                   unfinished;
  logic [TIME_W-1:0]    clock_now;

  rsp_item_t            due_results[$];

  function automatic logic [TIME_W-1:0] sat_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic tick_clock();
    if (clock_now != TIME_MAX) clock_now++;
  endtask

  // Works out the result of one item and queues it.
  task automatic schedule_item(input cmd_item_t c);
    rsp_item_t          r;
    int                 best;
    int                 i;
    logic [BURST_W-1:0] best_left;
    r         = '0;
    best      = -1;
    best_left = '0;
    if (c.kind == KIND_LOAD) begin
      if (loaded >= DEF_MAX_PROCS || c.burst_time == '0) begin
        r.load_error = 1'b1;
      end else begin
        arrival_of[loaded]   = c.arrival_time;
        burst_of[loaded]     = c.burst_time;
        left_of[loaded]      = c.burst_time;
        first_run_of[loaded] = '0;
        loaded++;
        unfinished++;
      end
    end else if (unfinished != 0) begin
      for (i = 0; i < loaded; i++) begin
        if (TIME_W'(arrival_of[i]) <= clock_now && left_of[i] != '0 &&
            (best < 0 || left_of[i] < best_left)) begin
          best      = i;
          best_left = left_of[i];
        end
      end
      if (best < 0) begin
        tick_clock();
      end else begin
        if (left_of[best] == burst_of[best])
          first_run_of[best] = sat_diff(clock_now, TIME_W'(arrival_of[best]));
        left_of[best]--;
        tick_clock();
        r.ran_id = RAN_ID_W'(best + 1);
        if (left_of[best] == '0) begin
          r.finished        = 1'b1;
          r.completion_time = clock_now;
          r.turnaround      = sat_diff(clock_now, TIME_W'(arrival_of[best]));
          r.waiting         = sat_diff(r.turnaround, TIME_W'(burst_of[best]));
          r.response        = first_run_of[best];
          unfinished--;
        end
      end
    end
    r.time_now = clock_now;
    r.all_done = (unfinished == 0);
    due_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= REPORT_CAP) $display("[%0t] ERROR: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
  endtask

  task automatic check_result(input rsp_item_t got);
    rsp_item_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result item arrived with none outstanding");
    end else begin
      want = due_results.pop_front();
      check_field("load_error", 32'(got.load_error), 32'(want.load_error));
      check_field("ran_id", 32'(got.ran_id), 32'(want.ran_id));
      check_field("time_now", 32'(got.time_now), 32'(want.time_now));
      check_field("finished", 32'(got.finished), 32'(want.finished));
      check_field("completion_time", 32'(got.completion_time),
                  32'(want.completion_time));
      check_field("turnaround", 32'(got.turnaround), 32'(want.turnaround));
      check_field("waiting", 32'(got.waiting), 32'(want.waiting));
      check_field("response", 32'(got.response), 32'(want.response));
      check_field("all_done", 32'(got.all_done), 32'(want.all_done));
    end
  endtask

  // A result never leaves in the cycle its item is taken, so the result side
  // is checked before the new item is predicted.
  always @(posedge clk) begin
    if (rst) begin
      loaded     = 0;
      unfinished = 0;
      clock_now  = '0;
      fail_count = 0;
      due_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if (cmd_valid && !cmd_stall) schedule_item(cmd);
    end
    pending = due_results.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler testbench
// Drives load and tick items into the scheduler under random idling on both
// channels and one long receiver hold-off; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
  import srtf_pkg::*;

  localparam int ITEM_COUNT   = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;
  int        fail_count;
  int        pending;

  // Idle rates in percent for the sender and the receiver. They start with
  // a slow receiver, swap a third of the way through, and drop to zero after two thirds.
  int   send_idle_pct = 23;
  int   rcv_idle_pct  = 70;
  logic want_hold     = 1'b0;
  logic hold_served   = 1'b0;

  // The stimulus keeps a rough view of the block: how many loads will be
  // taken into the table and how many ticks it has sent. The tick count is
  // an upper bound on elapsed time and is used to place arrivals near "now".
  int loads_taken = 0;
  int ticks_sent  = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  srtf_preemptive_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  srtf_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offers one item and returns at the edge where it is taken. Valid is only
  // lowered during an idle gap, so back-to-back items keep it high without a
  // second assignment in the same step.
  task automatic send_item(input cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic send_load(input logic [ARRIVAL_W-1:0] arrival,
                           input logic [BURST_W-1:0]   burst);
    cmd_item_t it;
    it.kind         = KIND_LOAD;
    it.arrival_time = arrival;
    it.burst_time   = burst;
    if (burst != '0 && loads_taken < DEF_MAX_PROCS) loads_taken++;
    send_item(it);
  endtask

  // Tick items carry random junk in the load fields; the block must ignore it.
  task automatic send_tick();
    cmd_item_t it;
    it.kind         = KIND_TICK;
    it.arrival_time = ARRIVAL_W'($urandom);
    it.burst_time   = BURST_W'($urandom);
    ticks_sent++;
    send_item(it);
  endtask

  // Receiver: random stalls at the current rate, plus one long hold-off when
  // the stimulus asks for it. During the hold the sender keeps offering, so
  // the output register fills and the block pushes back on its input.
  always begin
    @(posedge clk);
    if (want_hold && !hold_served) begin
      hold_served = 1'b1;
      repeat (HOLD_CYCLES) begin
        rsp_stall <= 1'b1;
        @(posedge clk);
      end
    end
    rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int                   k;
    int                   pick;
    int                   soon;
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---------------- Directed part ----------------
    // A tick with nothing loaded changes nothing and reports all done.
    send_tick();
    // A zero burst is refused, here with the largest arrival time.
    send_load('1, '0);
    // Process 1 arrives at time 2, so the next two ticks are idle ticks.
    send_load(16'd2, 12'd3);
    send_tick();
    send_tick();
    // Process 2 is loaded after time has moved and has already arrived. It
    // ties with process 1 on remaining work; the lower slot must win.
    send_load(16'd0, 12'd3);
    send_tick();
    // Process 3 has the shortest possible burst and arrives at time 3, so it
    // preempts process 1 and finishes on its first run.
    send_load(16'd3, 12'd1);
    send_tick();
    // Run processes 1 and 2 to completion, then tick once more with nothing
    // left to run.
    repeat (5) send_tick();
    send_tick();

    // ---------------- Random part ----------------
    // Mostly ticks, with well-formed loads arriving around the current time
    // so that processes overlap and preempt each other. A few loads are
    // noise: zero bursts while the table has room, anything once it is full.
    for (k = 0; k < ITEM_COUNT; k++) begin
      if (k == ITEM_COUNT / 3) begin
        send_idle_pct = 70;
        rcv_idle_pct  = 23;
      end
      if (k == 2 * ITEM_COUNT / 3) begin
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
      end
      if (k == 3 * ITEM_COUNT / 4) want_hold = 1'b1;

      pick = $urandom_range(99);
      if (pick < 5 && loads_taken < DEF_MAX_PROCS) begin
        soon    = ticks_sent + $urandom_range(12);
        arrival = ARRIVAL_W'((soon > 4) ? soon - 4 : 0);
        burst   = ($urandom_range(9) == 0) ? BURST_W'($urandom_range(90, 40))
                                           : BURST_W'($urandom_range(20, 1));
        send_load(arrival, burst);
      end else if (pick < 8) begin
        burst = (loads_taken < DEF_MAX_PROCS) ? '0 : BURST_W'($urandom);
        send_load(ARRIVAL_W'($urandom), burst);
      end else begin
        send_tick();
      end
    end

    // ---------------- Full table ----------------
    // Fill any free slots with processes that never arrive and carry the
    // largest burst, except the last slot, which arrives at once and runs
    // briefly. One more load then hits the full table, and the closing ticks
    // run the last slot and then idle while the rest wait to arrive.
    while (loads_taken < DEF_MAX_PROCS) begin
      if (loads_taken == DEF_MAX_PROCS - 1) send_load('0, 12'd2);
      else send_load('1, '1);
    end
    send_load('1, '1);
    repeat (6) send_tick();

    // ---------------- Drain and verdict ----------------
    cmd_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
